@@ hw/rtl/pvx_pkg.sv @@
// Package for the peak and valley extractor: beat types, queue entry and status types,
// sizing constants and point kind codes.
// Depends on nothing; every module of the block imports it.
package pvx_pkg;

   localparam int unsigned SAMPLE_BITS = 16;
   localparam int unsigned TIME_BITS   = 16;
   localparam int unsigned MAX_LEN     = 65536;

   // Highest index a point can carry: the record length bound or the widest time value.
   localparam int unsigned TIME_CAP_INT =
      ((MAX_LEN - 1) > ((1 << TIME_BITS) - 1)) ? ((1 << TIME_BITS) - 1) : (MAX_LEN - 1);
   localparam logic [TIME_BITS-1:0] TIME_CAP = TIME_BITS'(TIME_CAP_INT);

   localparam int unsigned QUEUE_DEPTH    = 4;
   localparam int unsigned QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic KIND_PEAK   = 1'b0;
   localparam logic KIND_VALLEY = 1'b1;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last_sample;
   } req_type;

   typedef struct packed {
      logic [TIME_BITS-1:0]          point_time;
      logic signed [SAMPLE_BITS-1:0] point_value;
      logic                          point_kind;
      logic                          last_point;
   } point_type;

   // One queue entry: the points caused by one sample, first_point always present.
   typedef struct packed {
      logic      has_second;
      point_type first_point;
      point_type second_point;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

@@ hw/rtl/pvx_front.sv @@
// Front end of the peak and valley extractor: accepts samples, tracks the slope
// and builds the queue entry of points each sample causes. Depends on pvx_pkg.
module pvx_front
   import pvx_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  logic    queue_full,
   output logic    push_valid,
   output job_type push_job
);

   typedef enum logic [1:0] {
      DIR_NONE,
      DIR_UP,
      DIR_DOWN
   } dir_type;

   dir_type                       slope_dir_ff, slope_dir_in;
   logic signed [SAMPLE_BITS-1:0] prev_value_ff, prev_value_in;
   logic signed [SAMPLE_BITS-1:0] held_value_ff, held_value_in;
   logic [TIME_BITS-1:0]          held_time_ff, held_time_in;
   logic [TIME_BITS-1:0]          sample_count_ff, sample_count_in;

   logic      accept;
   logic      first;
   logic      step_up;
   logic      step_down;
   dir_type   step_dir;
   logic      reversal;
   logic      trailing;
   point_type rev_point;
   point_type trail_point;
   point_type end_point;
   point_type start_point;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign first     = (sample_count_ff == '0);

   assign step_up   = req_data.sample > prev_value_ff;
   assign step_down = req_data.sample < prev_value_ff;

   always_comb begin
      priority if (step_up) begin
         step_dir = DIR_UP;
      end else if (step_down) begin
         step_dir = DIR_DOWN;
      end else begin
         step_dir = DIR_NONE;
      end
   end

   // A reversal is reported at the start of the run that preceded it.
   assign reversal = !first && (step_dir != DIR_NONE) && (slope_dir_ff != DIR_NONE)
                     && (slope_dir_ff != step_dir);
   // A flat run at the end of a falling record counts as rising.
   assign trailing = !first && req_data.last_sample && (step_dir == DIR_NONE)
                     && (slope_dir_ff == DIR_DOWN) && (held_time_ff != sample_count_ff);

   always_comb begin
      rev_point.point_time  = held_time_ff;
      rev_point.point_value = held_value_ff;
      rev_point.point_kind  = (slope_dir_ff == DIR_UP) ? KIND_PEAK : KIND_VALLEY;
      rev_point.last_point  = 1'b0;

      trail_point.point_time  = held_time_ff;
      trail_point.point_value = held_value_ff;
      trail_point.point_kind  = KIND_VALLEY;
      trail_point.last_point  = 1'b0;

      end_point.point_time  = sample_count_ff;
      end_point.point_value = req_data.sample;
      end_point.point_kind  = KIND_PEAK;
      end_point.last_point  = 1'b1;

      start_point.point_time  = '0;
      start_point.point_value = req_data.sample;
      start_point.point_kind  = KIND_PEAK;
      start_point.last_point  = req_data.last_sample;
   end

   always_comb begin
      push_job.second_point = end_point;
      push_job.has_second   = (reversal || trailing) && req_data.last_sample;
      priority if (first) begin
         push_job.first_point = start_point;
      end else if (reversal) begin
         push_job.first_point = rev_point;
      end else if (trailing) begin
         push_job.first_point = trail_point;
      end else begin
         push_job.first_point = end_point;
      end
      push_valid = accept && (first || reversal || trailing || req_data.last_sample);
   end

   always_comb begin
      slope_dir_in    = slope_dir_ff;
      prev_value_in   = prev_value_ff;
      held_value_in   = held_value_ff;
      held_time_in    = held_time_ff;
      sample_count_in = sample_count_ff;
      if (accept) begin
         if (req_data.last_sample) begin
            slope_dir_in    = DIR_NONE;
            prev_value_in   = '0;
            held_value_in   = '0;
            held_time_in    = '0;
            sample_count_in = '0;
         end else begin
            if (first) begin
               slope_dir_in  = DIR_NONE;
               held_time_in  = '0;
               held_value_in = req_data.sample;
            end else if (step_dir != DIR_NONE) begin
               slope_dir_in  = step_dir;
               held_time_in  = sample_count_ff;
               held_value_in = req_data.sample;
            end
            prev_value_in   = req_data.sample;
            sample_count_in = (sample_count_ff < TIME_CAP) ?
                              sample_count_ff + TIME_BITS'(1) : TIME_CAP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slope_dir_ff    <= DIR_NONE;
         prev_value_ff   <= '0;
         held_value_ff   <= '0;
         held_time_ff    <= '0;
         sample_count_ff <= '0;
      end else begin
         slope_dir_ff    <= slope_dir_in;
         prev_value_ff   <= prev_value_in;
         held_value_ff   <= held_value_in;
         held_time_ff    <= held_time_in;
         sample_count_ff <= sample_count_in;
      end
   end

endmodule

@@ hw/rtl/pvx_queue.sv @@
// Short first-in first-out queue of point entries between the front and back ends
// of the peak and valley extractor. Depends on pvx_pkg.
module pvx_queue
   import pvx_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head_job,
   output queue_status_type status
);

   job_type                   entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign head_job     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      unique case ({push_valid, pop})
         2'b10:   count_in = count_ff + QUEUE_CNT_BITS'(1);
         2'b01:   count_in = count_ff - QUEUE_CNT_BITS'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push_valid && status.full))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && status.empty))
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_count_tracks_ptrs: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[QUEUE_PTR_BITS-1:0])
      else $error("queue pointers disagree with count");
`endif

endmodule

@@ hw/rtl/pvx_back.sv @@
// Back end of the peak and valley extractor: takes queue entries and hands out
// their points one beat at a time through the output register. Depends on pvx_pkg.
module pvx_back
   import pvx_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  job_type          head_job,
   input  queue_status_type status,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output point_type        rsp_data
);

   logic      rsp_valid_ff, rsp_valid_in;
   point_type rsp_data_ff, rsp_data_in;
   logic      has_second_ff, has_second_in;
   point_type second_ff, second_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop       = out_free && !has_second_ff && !status.empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      has_second_in = has_second_ff;
      second_in     = second_ff;
      if (out_free) begin
         priority if (has_second_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = second_ff;
            has_second_in = 1'b0;
         end else if (!status.empty) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = head_job.first_point;
            has_second_in = head_job.has_second;
            second_in     = head_job.second_point;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      second_ff   <= second_in;
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         has_second_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         has_second_ff <= has_second_in;
      end
   end

`ifndef SYNTHESIS
   a_second_behind_first: assert property (@(posedge clock) disable iff (reset)
      has_second_ff |-> rsp_valid_ff)
      else $error("second point pending without a point on show");

   a_second_is_last: assert property (@(posedge clock) disable iff (reset)
      has_second_ff |-> (second_ff.last_point && !rsp_data_ff.last_point))
      else $error("pending second point is not the record end");

   a_no_pop_with_pending: assert property (@(posedge clock) disable iff (reset)
      has_second_ff |-> !pop)
      else $error("queue popped while a second point is pending");
`endif

endmodule

@@ hw/rtl/peak_valley_extractor.sv @@
// Top level of the peak and valley extractor: joins front end, point queue and back end.
// Depends on pvx_pkg, pvx_front, pvx_queue and pvx_back.
//
// The block takes one signed sample per beat, with last_sample marking the end of a record,
// and returns the turning points of the record: the first sample, every slope reversal and
// the last sample, each with its index in the record, its value and its kind (peak or
// valley; both record ends are given as peaks). Flat stretches take the direction of the
// next nonzero step, so a reversal across a plateau is reported at the plateau's first
// sample, and a flat run at the end of a falling record yields a valley at its start just
// before the final point. The index stops counting at the record length bound less one
// (or 65535). A sample causes no, one or two points. The front end takes a sample in every
// cycle while the queue is not full, and writes the points it causes as one entry into a
// four-entry queue; the back end reads an entry and presents its points through the output
// register, one beat per cycle while rsp_ready does not hold it. The output side thus
// sustains one point per cycle when not stalled, so only samples that cause two points
// consume output time faster than they arrive; the queue depth sets how many of those the
// block absorbs before req_ready drops. When the output side is not stalled, the points of
// an accepted sample are written into a queue entry and from there loaded into the output
// register, where rsp_valid shows them. There are no configuration registers.
module peak_valley_extractor
   import pvx_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req_data,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output point_type rsp_data
);

   logic             push_valid;
   job_type          push_job;
   logic             pop;
   job_type          head_job;
   queue_status_type queue_status;

   // The front end holds all record state; it stalls only when the queue is full.
   pvx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_status.full),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   // The queue decouples the two ends so that a stalled output does not at once stop input.
   pvx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pop        (pop),
      .head_job   (head_job),
      .status     (queue_status)
   );

   // The back end splits two-point entries into separate beats on the output channel.
   pvx_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .status    (queue_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
